>>> sv/red_pkg.sv
`timescale 1ns / 1ps
package red_pkg;

  localparam int DefTaps         = 16;
  localparam int DefGainAvgLen   = 20;
  localparam int DefWarmup       = 10000;
  localparam int DefMeanWeightDiv = 1000;

  localparam logic [2:0] RegGainRise    = 3'd0;
  localparam logic [2:0] RegGainFall    = 3'd1;
  localparam logic [2:0] RegThresholdSd = 3'd2;
  localparam logic [2:0] RegLockout     = 3'd3;
  localparam logic [2:0] RegSpeedLimit  = 3'd4;
  localparam logic [2:0] RegStimEnable  = 3'd5;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdCoef   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAP_RD,
    ST_TAP_X,
    ST_TAP_Y,
    ST_FILT_END,
    ST_MEAN,
    ST_DEV,
    ST_GAIN_SUM,
    ST_DIV,
    ST_DIV_REM,
    ST_DIV_END,
    ST_ENV,
    ST_DECIDE,
    ST_OUT
  } state_t;

endpackage

>>> sv/red_ram.sv
`timescale 1ns / 1ps
module red_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/ripple_envelope_detector.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (low first)                          | tuser
// s_axis  | in  | sample, stamp, speed, coef_index, coef_num, coef_den | cmd
// m_axis  | out | stim, envelope, mean_level, deviation, since_last   | -
// a sample runs the filter taps, then updates mean and deviation, then the gain
// average, envelope and decision; with stimulation enabled mean and deviation are
// skipped, and in lockout or warm-up only the taps run; one shared 33x33 multiplier
// does the taps, the envelope, the threshold and the reciprocal divisions
// s_axis_tready is low while a request works or its result waits, and after rst
// while the x/y history is swept to zero
module ripple_envelope_detector #(
  parameter int Taps          = red_pkg::DefTaps,
  parameter int GainAvgLen    = red_pkg::DefGainAvgLen,
  parameter int Warmup        = red_pkg::DefWarmup,
  parameter int MeanWeightDiv = red_pkg::DefMeanWeightDiv
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // sample, stamp, speed, coef_index, coef_num, coef_den
  input  logic         s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // stim, envelope, mean_level, deviation, since_last
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import red_pkg::*;

  localparam int TW = $clog2(Taps);
  localparam int GW = (GainAvgLen > 1) ? $clog2(GainAvgLen) : 1;

  localparam logic [31:0] RecipMean = 32'(64'd4294967295 / 64'(MeanWeightDiv));
  localparam logic [31:0] RecipGain = 32'(64'd4294967295 / 64'(GainAvgLen));
  localparam logic [1:0]  JobMean   = 2'd0;
  localparam logic [1:0]  JobDev    = 2'd1;
  localparam logic [1:0]  JobGain   = 2'd2;

  state_t state, state_next;

  logic [15:0] gain_rise, gain_fall, threshold_sd, speed_limit;
  logic [23:0] lockout_ticks;
  logic        stim_enable;

  logic [15:0] in_sample;
  logic [31:0] in_stamp;
  logic [15:0] in_speed;
  logic        lockout;

  logic [TW-1:0] tap_pointer, p, tcnt;
  logic [TW:0]   clr_cnt;
  logic          clr_busy;

  logic [GW-1:0] gain_pointer, gcnt;
  logic [15:0]   gain_history [GainAvgLen];
  logic [GainAvgLen-1:0] gvalid;

  logic [13:0] warmup_count;
  logic [31:0] mean_reg, dev_reg, env_reg, last_stim_stamp;
  logic [15:0] env_gain;

  logic signed [71:0] acc;
  logic signed [31:0] yfilt;
  logic [31:0] yabs;
  logic        stim;
  logic [31:0] since;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_r;
  assign mul_r = mul_a * mul_b;

  // division by a constant: reciprocal multiply, then one remainder correction
  logic [31:0] dv_num, dv_q, dv_rem, dv_qc, dv_res;
  logic [15:0] dv_den;
  logic        dv_neg;
  logic [1:0]  dv_job;

  // memories
  logic          x_we, y_we, c_we;
  logic [TW-1:0] x_wa, c_wa, x_ra, c_ra;
  logic [31:0]   x_wd, y_wd, x_rd, y_rd, num_rd, den_rd;
  logic          c_hit;

  red_ram #(.Width(32), .Depth(Taps)) u_x (.clk, .we(x_we), .waddr(x_wa),
    .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));
  red_ram #(.Width(32), .Depth(Taps)) u_y (.clk, .we(y_we), .waddr(x_wa),
    .wdata(y_wd), .raddr(x_ra), .rdata(y_rd));
  red_ram #(.Width(32), .Depth(Taps)) u_num (.clk, .we(c_we), .waddr(c_wa),
    .wdata(s_axis_tdata[101:70]), .raddr(c_ra), .rdata(num_rd));
  red_ram #(.Width(32), .Depth(Taps)) u_den (.clk, .we(c_we), .waddr(c_wa),
    .wdata(s_axis_tdata[133:102]), .raddr(c_ra), .rdata(den_rd));

  logic s_acc;
  assign s_axis_tready = (state == ST_IDLE) && !clr_busy && !m_axis_tvalid;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  assign c_hit = ({1'b0, s_axis_tdata[69:64]} < 7'(Taps));
  assign c_we  = s_acc && (s_axis_tuser == CmdCoef) && c_hit;
  assign c_wa  = s_axis_tdata[64 +: TW];
  assign c_ra  = tcnt;

  logic [TW-1:0] j;
  assign j = TW'((({1'b0, p} + {1'b0, tcnt}) >= (TW+1)'(Taps)) ?
             ({1'b0, p} + {1'b0, tcnt} - (TW+1)'(Taps)) : ({1'b0, p} + {1'b0, tcnt}));
  assign x_ra = j;

  always_comb begin
    x_we = 1'b0; y_we = 1'b0; x_wa = p; x_wd = '0; y_wd = '0;
    if (clr_busy) begin
      x_we = 1'b1; y_we = 1'b1; x_wa = clr_cnt[TW-1:0];
    end else if (state == ST_TAP_RD && tcnt == '0) begin
      x_we = 1'b1; y_we = 1'b1;
      x_wd = lockout ? 32'd0 : {{16{in_sample[15]}}, in_sample};
    end else if (state == ST_FILT_END) begin
      y_we = 1'b1; y_wd = yfilt;
    end
  end

  // write-through of the fresh entry at tap zero
  logic [31:0] xr, yr;
  logic        first_tap;
  always_comb begin
    xr = x_rd; yr = y_rd;
    if (first_tap) begin
      xr = lockout ? 32'd0 : {{16{in_sample[15]}}, in_sample};
      yr = '0;
    end
  end

  always_comb begin
    mul_a = '0; mul_b = '0;
    case (state)
      ST_TAP_X: begin mul_a = {xr[31], xr}; mul_b = {num_rd[31], num_rd}; end
      ST_TAP_Y: begin mul_a = {yr[31], yr}; mul_b = {den_rd[31], den_rd}; end
      ST_DIV:   begin mul_a = {1'b0, dv_num};
                      mul_b = {1'b0, (dv_job == JobGain) ? RecipGain : RecipMean}; end
      ST_DIV_REM: begin mul_a = {1'b0, dv_q}; mul_b = {17'd0, dv_den}; end
      ST_ENV:   begin mul_a = 33'(signed'({1'b0, yabs}) - signed'({1'b0, env_reg}));
                      mul_b = {17'd0, env_gain}; end
      ST_DECIDE: begin mul_a = {17'd0, threshold_sd}; mul_b = {1'b0, dev_reg}; end
      default: ;
    endcase
  end

  logic signed [71:0] accs;
  always_comb begin
    accs  = acc >>> 12;
    if (accs > 72'sd2147483647) yfilt = 32'h7fffffff;
    else if (accs < -72'sd2147483648) yfilt = 32'h80000000;
    else yfilt = accs[31:0];
  end

  assign dv_qc  = dv_q + {31'd0, (dv_rem >= {16'd0, dv_den})};
  assign dv_res = dv_neg ? (32'd0 - dv_qc) : dv_qc;

  logic signed [65:0] env_sum;
  assign env_sum = 66'(signed'({1'b0, env_reg})) + (mul_r >>> 16);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_acc && s_axis_tuser == CmdSample) state_next = ST_TAP_RD;
               else if (s_acc) state_next = ST_OUT;
      ST_TAP_RD: state_next = ST_TAP_X;
      ST_TAP_X:  state_next = ST_TAP_Y;
      ST_TAP_Y:  state_next = (tcnt == TW'(Taps-1)) ? ST_FILT_END : ST_TAP_RD;
      ST_FILT_END: state_next = (lockout || warmup_count < 14'(Warmup)) ? ST_OUT :
                   (stim_enable ? ST_GAIN_SUM : ST_MEAN);
      ST_MEAN: state_next = ST_DIV;
      ST_DEV:  state_next = ST_DIV;
      ST_GAIN_SUM: state_next = (gcnt == GW'(GainAvgLen-1)) ? ST_DIV : ST_GAIN_SUM;
      ST_DIV:     state_next = ST_DIV_REM;
      ST_DIV_REM: state_next = ST_DIV_END;
      ST_DIV_END: state_next = (dv_job == JobMean) ? ST_DEV :
                               (dv_job == JobDev) ? ST_GAIN_SUM : ST_ENV;
      ST_ENV:    state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic [31:0] gsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_rise <= '0; gain_fall <= '0; threshold_sd <= '0;
      lockout_ticks <= '0; speed_limit <= '0; stim_enable <= 1'b0;
      tap_pointer <= '0; gain_pointer <= '0; gvalid <= '0;
      warmup_count <= '0; mean_reg <= '0; dev_reg <= '0; env_reg <= '0;
      env_gain <= '0; last_stim_stamp <= '0; m_axis_tvalid <= 1'b0;
      clr_cnt <= '0; clr_busy <= 1'b1;
    end else begin
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (TW+1)'(Taps-1)) clr_busy <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          RegGainRise:    gain_rise <= cfg_data[15:0];
          RegGainFall:    gain_fall <= cfg_data[15:0];
          RegThresholdSd: threshold_sd <= cfg_data[15:0];
          RegLockout:     lockout_ticks <= cfg_data;
          RegSpeedLimit:  speed_limit <= cfg_data[15:0];
          RegStimEnable:  stim_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (s_acc) begin
          in_sample <= s_axis_tdata[15:0];
          in_stamp  <= s_axis_tdata[47:16];
          in_speed  <= s_axis_tdata[63:48];
          since     <= (s_axis_tuser == CmdSample) ? s_axis_tdata[47:16] - last_stim_stamp
                                                    : 32'd0;
          lockout   <= (s_axis_tdata[47:16] - last_stim_stamp) < {8'd0, lockout_ticks};
          p <= tap_pointer; tcnt <= '0; acc <= '0; stim <= 1'b0; first_tap <= 1'b1;
        end
        ST_TAP_X: acc <= acc + 72'(mul_r);
        ST_TAP_Y: begin
          acc <= acc - 72'(mul_r >>> 16);
          tcnt <= tcnt + 1'b1;
          first_tap <= 1'b0;
        end
        ST_FILT_END: begin
          tap_pointer <= (p == '0) ? TW'(Taps-1) : p - 1'b1;
          yabs <= yfilt[31] ? 32'd0 - yfilt : yfilt;
          if (!lockout && warmup_count < 14'(Warmup)) warmup_count <= warmup_count + 1'b1;
          gcnt <= '0; gsum <= '0;
        end
        ST_MEAN: begin
          dv_job <= JobMean;
          dv_neg <= yabs < mean_reg;
          dv_num <= (yabs < mean_reg) ? mean_reg - yabs : yabs - mean_reg;
          dv_den <= 16'(MeanWeightDiv);
        end
        ST_DEV: begin
          dv_job <= JobDev;
          dv_neg <= (yabs < mean_reg ? mean_reg - yabs : yabs - mean_reg) < dev_reg;
          dv_num <= ((yabs < mean_reg ? mean_reg - yabs : yabs - mean_reg) < dev_reg) ?
            dev_reg - (yabs < mean_reg ? mean_reg - yabs : yabs - mean_reg) :
            (yabs < mean_reg ? mean_reg - yabs : yabs - mean_reg) - dev_reg;
        end
        ST_GAIN_SUM: begin
          gsum <= gsum + (gvalid[gcnt] ? {16'd0, gain_history[gcnt]} : 32'd0);
          gcnt <= gcnt + 1'b1;
          if (gcnt == GW'(GainAvgLen-1)) begin
            dv_job <= JobGain; dv_neg <= 1'b0;
            dv_num <= gsum + (gvalid[gcnt] ? {16'd0, gain_history[gcnt]} : 32'd0);
            dv_den <= 16'(GainAvgLen);
          end
        end
        ST_DIV:     dv_q <= mul_r[63:32];
        ST_DIV_REM: dv_rem <= dv_num - mul_r[31:0];
        ST_DIV_END: begin
          case (dv_job)
            JobMean: mean_reg <= mean_reg + dv_res;
            JobDev:  dev_reg <= dev_reg + dv_res;
            default: dv_q <= dv_qc;
          endcase
        end
        ST_ENV: begin
          if (env_sum < 0) env_reg <= '0;
          else if (env_sum > 66'sh0FFFFFFFF) env_reg <= '1;
          else env_reg <= env_sum[31:0];
          env_gain <= dv_q[15:0];
          gain_history[gain_pointer] <= (yabs > env_reg) ? gain_rise : gain_fall;
          gvalid[gain_pointer] <= 1'b1;
          gain_pointer <= (gain_pointer == GW'(GainAvgLen-1)) ? '0 : gain_pointer + 1'b1;
        end
        ST_DECIDE: begin
          if ({32'd0, env_reg} > {32'd0, mean_reg} + 64'(mul_r[55:8]) && stim_enable &&
              in_speed <= speed_limit) begin
            stim <= 1'b1; since <= '0; last_stim_stamp <= in_stamp;
          end
        end
        ST_OUT: m_axis_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, since, dev_reg, mean_reg, env_reg, stim};
endmodule

>>> sv/red_checker.sv
`timescale 1ns / 1ps
module red_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result waits");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_stim_since: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[128:97] == 32'd0)
    else $error("stim with nonzero since");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("double accept");
endmodule

bind ripple_envelope_detector red_checker u_red_checker (.*);
